// ----- sv/evapotranspiration_partition_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ET partition core
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef EVAPOTRANSPIRATION_PARTITION_CORE_ASSERT_SVH
`define EVAPOTRANSPIRATION_PARTITION_CORE_ASSERT_SVH

// same-cycle implication
`define ETP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etp: implication check failed");

// next-cycle implication
`define ETP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("etp: next-cycle check failed");

`endif

// ----- sv/etp_pkg.sv -----
// ----------------------------------------------------------------------------
// ET partition package
// Widths, codes, stage payload types and small arithmetic helpers shared by
// the pipeline modules.
// ----------------------------------------------------------------------------
package etp_pkg;

   localparam int DEPTH_W = 40;
   localparam int COEF_W  = 18;
   localparam int RATIO_W = 17;
   localparam int KIND_W  = 2;
   localparam int Q_SHIFT = 16;

   localparam logic [RATIO_W-1:0] ONE_Q16       = 17'h10000;
   localparam logic [DEPTH_W-1:0] THRESH_RESET  = 40'd1000;

   // et_mode codes
   localparam logic MODE_POTENTIAL = 1'b0;
   localparam logic MODE_USER      = 1'b1;

   // register indexes
   localparam logic CSR_ET_MODE = 1'b0;
   localparam logic CSR_WET_DRY = 1'b1;

   // flow kind codes
   localparam logic [KIND_W-1:0] KIND_OVERLAND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANNEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHAN_OVL = 2'd2;

   typedef logic [DEPTH_W-1:0] depth_type;

   // one input cell
   typedef struct packed {
      depth_type            potential_et;
      depth_type            user_actual_et;
      logic [COEF_W-1:0]    et_coefficient;
      logic [RATIO_W-1:0]   canopy_ratio;
      depth_type            canopy_store;
      depth_type            overland_depth;
      depth_type            channel_depth;
      depth_type            soil_water;
      logic [KIND_W-1:0]    flow_kind;
      logic                 water_cover;
      logic                 soil_saturation_zero;
   } req_type;

   // canopy split -> blend
   typedef struct packed {
      logic                 mode;
      depth_type            transp;
      depth_type            canopy_demand;  // full demand if the store falls short, else zero
      depth_type            surf_et;        // open water or soil term
      logic [RATIO_W-1:0]   cover_q;
      logic [RATIO_W-1:0]   open;
      depth_type            user_et;
      depth_type            store;
      depth_type            overland;
      depth_type            channel;
      depth_type            soil;
      logic [KIND_W-1:0]    kind;
   } cnp_type;

   // blend -> drain
   typedef struct packed {
      logic                 mode;
      depth_type            aet;
      depth_type            land;
      depth_type            store;
      depth_type            overland;
      depth_type            channel;
      depth_type            soil;
      logic [KIND_W-1:0]    kind;
   } mix_type;

   // one result
   typedef struct packed {
      depth_type            actual_et;
      depth_type            land_surface_et;
      depth_type            new_canopy_store;
      depth_type            new_overland_depth;
      depth_type            new_channel_depth;
      depth_type            new_soil_water;
   } rsp_type;

   typedef struct packed {
      depth_type            depth;
      depth_type            rest;
   } draw_type;

   // clamp a grown sum to the depth width
   function automatic depth_type sat_depth(input logic [DEPTH_W+1:0] v);
      return (|v[DEPTH_W+1:DEPTH_W]) ? '1 : v[DEPTH_W-1:0];
   endfunction

   function automatic depth_type sat_sub(input depth_type a, input depth_type b);
      return (a > b) ? (a - b) : '0;
   endfunction

   // draw a surface depth down; small remainder is raised to the threshold
   function automatic draw_type draw_depth(input depth_type depth,
                                           input depth_type land,
                                           input depth_type thresh);
      draw_type  r;
      depth_type left;
      left = depth - land;
      if (depth == '0) begin
         r.depth = '0;
         r.rest  = land;
      end else if (depth > land) begin
         r.depth = (left < thresh) ? thresh : left;
         r.rest  = '0;
      end else begin
         r.depth = '0;
         r.rest  = land - depth;
      end
      return r;
   endfunction

endpackage

// ----- sv/etp_canopy.sv -----
// ----------------------------------------------------------------------------
// ET partition: demand and canopy split
// Stage 1 forms the ET demand and cover ratios, stage 2 splits the demand
// between canopy store and transpiration and picks the open-area term.
// ----------------------------------------------------------------------------
module etp_canopy (
   input  logic             clock,
   input  logic             reset,
   input  logic             et_mode,
   input  logic             in_valid,
   output logic             in_ready,
   input  etp_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output etp_pkg::cnp_type out_data
);

   typedef struct packed {
      logic                          mode;
      etp_pkg::depth_type            base;
      etp_pkg::depth_type            wet_et;
      logic                          is_water;
      logic                          no_soil;
      logic [etp_pkg::RATIO_W-1:0]   cover_q;
      logic [etp_pkg::RATIO_W-1:0]   open;
      etp_pkg::depth_type            user_et;
      etp_pkg::depth_type            store;
      etp_pkg::depth_type            overland;
      etp_pkg::depth_type            channel;
      etp_pkg::depth_type            soil;
      logic [etp_pkg::KIND_W-1:0]    kind;
   } dem_type;

   localparam int PROD_W = etp_pkg::DEPTH_W + etp_pkg::COEF_W;

   logic             s1_valid_ff, s2_valid_ff;
   logic             s1_ready, s2_ready;
   dem_type          s1_ff, s1_in;
   etp_pkg::cnp_type s2_ff, s2_in;
   logic [PROD_W-1:0] demand_prod;
   logic             wet_kind;

   // stage flow control
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   // stage 1: demand, ratios, open-water test
   always_comb begin
      demand_prod = PROD_W'(in_data.potential_et) * PROD_W'(in_data.et_coefficient);
      wet_kind    = 1'b0;
      case (in_data.flow_kind)
         etp_pkg::KIND_OVERLAND: wet_kind = (in_data.overland_depth != '0);
         etp_pkg::KIND_CHANNEL,
         etp_pkg::KIND_CHAN_OVL: wet_kind = (in_data.channel_depth != '0);
         default:                wet_kind = 1'b0;
      endcase
      s1_in.mode = et_mode;
      if (et_mode == etp_pkg::MODE_USER) begin
         s1_in.base   = in_data.user_actual_et;
         s1_in.wet_et = in_data.user_actual_et;
      end else begin
         s1_in.base   = (|demand_prod[PROD_W-1:PROD_W-2]) ? '1 :
                        demand_prod[PROD_W-3:etp_pkg::Q_SHIFT];
         s1_in.wet_et = in_data.potential_et;
      end
      s1_in.is_water = in_data.water_cover && wet_kind;
      s1_in.no_soil  = in_data.soil_saturation_zero;
      s1_in.cover_q  = (in_data.canopy_ratio > etp_pkg::ONE_Q16) ?
                       etp_pkg::ONE_Q16 : in_data.canopy_ratio;
      s1_in.open     = etp_pkg::ONE_Q16 - s1_in.cover_q;
      s1_in.user_et  = in_data.user_actual_et;
      s1_in.store    = in_data.canopy_store;
      s1_in.overland = in_data.overland_depth;
      s1_in.channel  = in_data.channel_depth;
      s1_in.soil     = in_data.soil_water;
      s1_in.kind     = in_data.flow_kind;
   end

   // stage 2: canopy store against demand
   always_comb begin
      s2_in.mode     = s1_ff.mode;
      s2_in.cover_q  = s1_ff.cover_q;
      s2_in.open     = s1_ff.open;
      s2_in.user_et  = s1_ff.user_et;
      s2_in.overland = s1_ff.overland;
      s2_in.channel  = s1_ff.channel;
      s2_in.soil     = s1_ff.soil;
      s2_in.kind     = s1_ff.kind;
      if (s1_ff.store == '0) begin
         s2_in.transp        = s1_ff.base;
         s2_in.canopy_demand = s1_ff.base;
         s2_in.store         = '0;
      end else if (s1_ff.store < s1_ff.base) begin
         s2_in.transp        = s1_ff.base - s1_ff.store;
         s2_in.canopy_demand = s1_ff.base;
         s2_in.store         = '0;
      end else begin
         s2_in.transp        = '0;
         s2_in.canopy_demand = '0;
         s2_in.store         = s1_ff.store - s1_ff.base;
      end
      if (s1_ff.is_water) begin
         s2_in.surf_et = s1_ff.wet_et;
      end else begin
         s2_in.surf_et = s1_ff.no_soil ? '0 : s1_ff.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

endmodule

// ----- sv/etp_blend.sv -----
// ----------------------------------------------------------------------------
// ET partition: ratio blend
// Stage 1 scales the transpiration, canopy and open-area terms by the cover
// ratios, stage 2 sums them into land-surface ET and, in potential mode, actual ET.
// ----------------------------------------------------------------------------
module etp_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  etp_pkg::cnp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output etp_pkg::mix_type out_data
);

   localparam int MUL_W  = etp_pkg::DEPTH_W + etp_pkg::RATIO_W;
   localparam int PART_W = MUL_W - etp_pkg::Q_SHIFT;

   typedef struct packed {
      logic                          mode;
      logic [PART_W-1:0]             part_transp;
      logic [PART_W-1:0]             part_canopy;
      logic [PART_W-1:0]             part_open;
      etp_pkg::depth_type            user_et;
      etp_pkg::depth_type            store;
      etp_pkg::depth_type            overland;
      etp_pkg::depth_type            channel;
      etp_pkg::depth_type            soil;
      logic [etp_pkg::KIND_W-1:0]    kind;
   } part_type;

   logic             s1_valid_ff, s2_valid_ff;
   logic             s1_ready, s2_ready;
   part_type         s1_ff, s1_in;
   etp_pkg::mix_type s2_ff, s2_in;
   logic [MUL_W-1:0] prod_transp, prod_canopy, prod_open;
   logic [etp_pkg::DEPTH_W+1:0] land_sum, aet_sum;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   // stage 1: three Q.16 products, truncated
   always_comb begin
      prod_transp = MUL_W'(in_data.transp) * MUL_W'(in_data.cover_q);
      prod_canopy = MUL_W'(in_data.canopy_demand) * MUL_W'(in_data.cover_q);
      prod_open   = MUL_W'(in_data.surf_et) * MUL_W'(in_data.open);
      s1_in.mode        = in_data.mode;
      s1_in.part_transp = prod_transp[MUL_W-1:etp_pkg::Q_SHIFT];
      s1_in.part_canopy = prod_canopy[MUL_W-1:etp_pkg::Q_SHIFT];
      s1_in.part_open   = prod_open[MUL_W-1:etp_pkg::Q_SHIFT];
      s1_in.user_et     = in_data.user_et;
      s1_in.store       = in_data.store;
      s1_in.overland    = in_data.overland;
      s1_in.channel     = in_data.channel;
      s1_in.soil        = in_data.soil;
      s1_in.kind        = in_data.kind;
   end

   // stage 2: totals, saturated to the depth width
   always_comb begin
      land_sum = (etp_pkg::DEPTH_W+2)'(s1_ff.part_transp) +
                 (etp_pkg::DEPTH_W+2)'(s1_ff.part_open);
      aet_sum  = (etp_pkg::DEPTH_W+2)'(s1_ff.part_canopy) +
                 (etp_pkg::DEPTH_W+2)'(s1_ff.part_open);
      s2_in.mode     = s1_ff.mode;
      s2_in.land     = etp_pkg::sat_depth(land_sum);
      s2_in.aet      = (s1_ff.mode == etp_pkg::MODE_USER) ? s1_ff.user_et :
                       etp_pkg::sat_depth(aet_sum);
      s2_in.store    = s1_ff.store;
      s2_in.overland = s1_ff.overland;
      s2_in.channel  = s1_ff.channel;
      s2_in.soil     = s1_ff.soil;
      s2_in.kind     = s1_ff.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

endmodule

// ----- sv/etp_drain.sv -----
// ----------------------------------------------------------------------------
// ET partition: drawdown
// Stage 1 draws the overland and channel depths down, stage 2 draws the soil
// and cuts the ET totals by any soil deficit in potential mode.
// ----------------------------------------------------------------------------
module etp_drain (
   input  logic               clock,
   input  logic               reset,
   input  etp_pkg::depth_type wet_dry_threshold,
   input  logic               in_valid,
   output logic               in_ready,
   input  etp_pkg::mix_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output etp_pkg::rsp_type   out_data
);

   typedef struct packed {
      logic                 mode;
      logic                 soil_go;
      etp_pkg::depth_type   residual;
      etp_pkg::depth_type   aet;
      etp_pkg::depth_type   land;
      etp_pkg::depth_type   store;
      etp_pkg::depth_type   overland;
      etp_pkg::depth_type   channel;
      etp_pkg::depth_type   soil;
   } srf_type;

   logic              s1_valid_ff, s2_valid_ff;
   logic              s1_ready, s2_ready;
   srf_type           s1_ff, s1_in;
   etp_pkg::rsp_type  s2_ff, s2_in;
   etp_pkg::draw_type draw_ovl, draw_chn;
   etp_pkg::depth_type deficit;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   // stage 1: surface drawdown by flow kind
   always_comb begin
      draw_ovl = etp_pkg::draw_depth(in_data.overland, in_data.land, wet_dry_threshold);
      draw_chn = etp_pkg::draw_depth(in_data.channel, in_data.land, wet_dry_threshold);
      s1_in.mode     = in_data.mode;
      s1_in.aet      = in_data.aet;
      s1_in.land     = in_data.land;
      s1_in.store    = in_data.store;
      s1_in.soil     = in_data.soil;
      s1_in.overland = in_data.overland;
      s1_in.channel  = in_data.channel;
      s1_in.soil_go  = 1'b0;
      s1_in.residual = '0;
      case (in_data.kind)
         etp_pkg::KIND_OVERLAND: begin
            s1_in.overland = draw_ovl.depth;
            s1_in.residual = draw_ovl.rest;
            s1_in.soil_go  = (draw_ovl.depth == '0);
         end
         etp_pkg::KIND_CHANNEL: begin
            s1_in.channel  = draw_chn.depth;
            s1_in.residual = draw_chn.rest;
            s1_in.soil_go  = (draw_chn.depth == '0);
         end
         etp_pkg::KIND_CHAN_OVL: begin
            // both drawn by the full land ET; only the channel feeds the soil
            s1_in.overland = draw_ovl.depth;
            s1_in.channel  = draw_chn.depth;
            s1_in.residual = draw_chn.rest;
            s1_in.soil_go  = (draw_chn.depth == '0);
         end
         default: begin
            // no drawdown at all
            s1_in.soil_go = 1'b0;
         end
      endcase
   end

   // stage 2: soil drawdown and deficit cut
   always_comb begin
      deficit                  = s1_ff.residual - s1_ff.soil;
      s2_in.actual_et          = s1_ff.aet;
      s2_in.land_surface_et    = s1_ff.land;
      s2_in.new_canopy_store   = s1_ff.store;
      s2_in.new_overland_depth = s1_ff.overland;
      s2_in.new_channel_depth  = s1_ff.channel;
      s2_in.new_soil_water     = s1_ff.soil;
      if (s1_ff.soil_go) begin
         if (s1_ff.soil > s1_ff.residual) begin
            s2_in.new_soil_water = s1_ff.soil - s1_ff.residual;
         end else begin
            s2_in.new_soil_water = '0;
            if (s1_ff.mode == etp_pkg::MODE_POTENTIAL) begin
               s2_in.actual_et       = etp_pkg::sat_sub(s1_ff.aet, deficit);
               s2_in.land_surface_et = etp_pkg::sat_sub(s1_ff.land, deficit);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

endmodule

// ----- sv/evapotranspiration_partition_core.sv -----
// Throughput: one cell per cycle unless rsp_tready stalls; six register stages
//   (demand multiply, canopy split, ratio products, totals, surface drawdown,
//   soil drawdown), each a full pipeline stage with its own valid bit and stall control.
// Reset (synchronous): empties the pipeline, et_mode = 0, threshold = 1000.
// ----------------------------------------------------------------------------
// ET partition core
// Splits a cell's ET among canopy, transpiration, open water and soil, then
// draws down surface, channel and soil water.
// ----------------------------------------------------------------------------
`include "evapotranspiration_partition_core_assert.svh"

module evapotranspiration_partition_core (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [39:0]  csr_wdata,
   // cell input
   input  logic         req_tvalid,
   output logic         req_tready,
   // potential_et[39:0], user_actual_et[79:40], et_coefficient[97:80],
   // canopy_ratio[114:98], canopy_store[154:115], overland_depth[194:155],
   // channel_depth[234:195], soil_water[274:235], zero pad[279:275]
   input  logic [279:0] req_tdata,
   // flow_kind[1:0], water_cover[2], soil_saturation_zero[3]
   input  logic [3:0]   req_tuser,
   // result
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // actual_et[39:0], land_surface_et[79:40], new_canopy_store[119:80],
   // new_overland_depth[159:120], new_channel_depth[199:160],
   // new_soil_water[239:200]
   output logic [239:0] rsp_tdata
);

   logic               et_mode_ff;
   etp_pkg::depth_type wet_dry_ff;

   etp_pkg::req_type   req;
   etp_pkg::cnp_type   cnp;
   etp_pkg::mix_type   mix;
   etp_pkg::rsp_type   rsp;
   logic               cnp_valid, cnp_ready;
   logic               mix_valid, mix_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         et_mode_ff <= etp_pkg::MODE_POTENTIAL;
         wet_dry_ff <= etp_pkg::THRESH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            etp_pkg::CSR_ET_MODE: et_mode_ff <= csr_wdata[0];
            etp_pkg::CSR_WET_DRY: wet_dry_ff <= csr_wdata;
            default:              et_mode_ff <= et_mode_ff;
         endcase
      end
   end

   // unpack the cell
   assign req.potential_et         = req_tdata[39:0];
   assign req.user_actual_et       = req_tdata[79:40];
   assign req.et_coefficient       = req_tdata[97:80];
   assign req.canopy_ratio         = req_tdata[114:98];
   assign req.canopy_store         = req_tdata[154:115];
   assign req.overland_depth       = req_tdata[194:155];
   assign req.channel_depth        = req_tdata[234:195];
   assign req.soil_water           = req_tdata[274:235];
   assign req.flow_kind            = req_tuser[1:0];
   assign req.water_cover          = req_tuser[2];
   assign req.soil_saturation_zero = req_tuser[3];

   etp_canopy u_canopy (
      .clock     (clock),
      .reset     (reset),
      .et_mode   (et_mode_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (cnp_valid),
      .out_ready (cnp_ready),
      .out_data  (cnp)
   );

   etp_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cnp_valid),
      .in_ready  (cnp_ready),
      .in_data   (cnp),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix)
   );

   etp_drain u_drain (
      .clock             (clock),
      .reset             (reset),
      .wet_dry_threshold (wet_dry_ff),
      .in_valid          (mix_valid),
      .in_ready          (mix_ready),
      .in_data           (mix),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_data          (rsp)
   );

   // pack the result
   assign rsp_tdata = {rsp.new_soil_water, rsp.new_channel_depth,
                       rsp.new_overland_depth, rsp.new_canopy_store,
                       rsp.land_surface_et, rsp.actual_et};

   // checks
   `ETP_ASSERT_IMPLY(a_cover_sum, clock, reset, cnp_valid,
      ({1'b0, cnp.cover_q} + {1'b0, cnp.open}) == {1'b0, etp_pkg::ONE_Q16})
   `ETP_ASSERT_IMPLY(a_transp_le_demand, clock, reset, cnp_valid,
      cnp.transp <= cnp.canopy_demand)
   `ETP_ASSERT_IMPLY(a_land_le_aet, clock, reset,
      mix_valid && (mix.mode == etp_pkg::MODE_POTENTIAL), mix.land <= mix.aet)

endmodule
